[rtl/usm_pkg.sv]
// Shared constants and codes for the unsharp-mask block.
package usm_pkg;

	// Field and register widths
	localparam int PIX_W      = 8;
	localparam int MASK_W     = 9;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 13;
	localparam int GAIN_W     = 10;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd2;

	// Register reset values
	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;
	localparam logic [GAIN_W-1:0]   GAIN_RST   = 10'd77;

	// Item kinds
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	// Gain is unsigned Q2.8
	localparam int GAIN_FRAC = 8;

endpackage

[rtl/unsharp_mask_box5_unit.sv]
// Unsharp mask with box blur: line store, window cell chain and sharpening pipeline.
// Throughput: one item per cycle while out_stall is low; the line store has one read and
// one write port. A result passes stages 1 to 6 and the output register after the beat
// that releases it, the beat HALF*W+HALF items after its pixel (W the effective row width).
// A beat is taken while the output register holds a result, as long as stages behind it drain.
// Reset: configuration returns to 640 x 480, gain 77; counters and window clear; the line
// store is not cleared.
module unsharp_mask_box5_unit #(
	parameter int MAX_WIDTH   = 1024,
	parameter int WINDOW_SIZE = 5
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [usm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [usm_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 kind,
	input  logic [usm_pkg::PIX_W-1:0]            pixel_in,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [usm_pkg::PIX_W-1:0]            sharpened,
	output logic [usm_pkg::PIX_W-1:0]            blurred,
	output logic signed [usm_pkg::MASK_W-1:0]    detail_mask,
	output logic                                 frame_end
);

	localparam int HALF    = WINDOW_SIZE / 2;
	localparam int LROWS   = WINDOW_SIZE - 1;
	localparam int PW      = usm_pkg::PIX_W;
	localparam int HW      = usm_pkg::HEIGHT_W;
	localparam int CW      = $clog2(MAX_WIDTH);
	localparam int DW      = $clog2(HALF * MAX_WIDTH + HALF + 1);
	localparam int AREA    = WINDOW_SIZE * WINDOW_SIZE;
	localparam int CSUM_W  = $clog2(255 * WINDOW_SIZE + 1);
	localparam int SMAX    = 255 * AREA;
	localparam int SUM_W   = $clog2(SMAX + 1);
	localparam int SH      = $clog2(SMAX * AREA + 1);
	localparam int RECIP   = ((2 ** SH) + AREA - 1) / AREA;
	localparam int RCP_W   = $clog2(RECIP + 1);
	localparam int PROD_W  = SUM_W + RCP_W;
	localparam int MAG_W   = PW + usm_pkg::GAIN_W - usm_pkg::GAIN_FRAC;
	localparam int SHARP_W = MAG_W + 2;

	// Configuration registers
	logic [usm_pkg::WIDTH_W-1:0]  cfg_width_q;
	logic [HW-1:0]                cfg_height_q;
	logic [usm_pkg::GAIN_W-1:0]   cfg_gain_q;
	logic                         cfg_hit;

	// Frame counters
	logic [CW-1:0] in_col_q;
	logic [HW-1:0] in_row_q;
	logic          in_done_q;
	logic [DW-1:0] prime_q;
	logic          started_q;
	logic [CW-1:0] ocol_q;
	logic [HW-1:0] orow_q;

	logic [CW-1:0] w_m1;
	logic [HW-1:0] h_m1;
	logic [DW-1:0] delay;
	logic          accept;
	logic          drop;
	logic          take;
	logic          emit0;
	logic          last0;
	logic          border0;
	logic          col_wrap;

	// Stage 1: line store read returns
	logic              v1_q;
	logic [PW-1:0]     val_s1;
	logic [CW-1:0]     col_s1;
	logic              emit_s1;
	logic              border_s1;
	logic              last_s1;
	logic              adv1;
	logic [LROWS*PW-1:0] rd_word;
	logic [LROWS*PW-1:0] wr_word;
	logic [WINDOW_SIZE-1:0][PW-1:0] col_vec;

	// Window cells
	logic [WINDOW_SIZE-1:0][WINDOW_SIZE-1:0][PW-1:0] win;
	logic [WINDOW_SIZE-1:0][CSUM_W-1:0]              csum;
	logic [SUM_W-1:0]                                win_sum;

	// Stage 2 onward
	logic              v2_q, v3_q, v4_q, v5_q, v6_q, vout_q;
	logic              en2, en3, en4, en5, en6, en_out;
	logic              border_s2, last_s2;
	logic              border_s3, last_s3;
	logic [SUM_W-1:0]  sum_s3;
	logic [PW-1:0]     pix_s3;
	logic              border_s4, last_s4;
	logic [PW-1:0]     pix_s4, blur_s4;
	logic              last_s5;
	logic [PW-1:0]     pix_s5, blur_s5;
	logic signed [usm_pkg::MASK_W-1:0] mask_s5;
	logic              last_s6, neg_s6;
	logic [PW-1:0]     pix_s6, blur_s6;
	logic signed [usm_pkg::MASK_W-1:0] mask_s6;
	logic [MAG_W-1:0]  mag_s6;
	logic [PROD_W-1:0] blur_prod;
	logic [PW-1:0]     blur_eff;
	logic [PW-1:0]     mask_abs;
	logic [PW+usm_pkg::GAIN_W-1:0] gain_prod;
	logic signed [SHARP_W-1:0] sharp_wide;
	logic [PW-1:0]     sharp_q, blur_q;
	logic signed [usm_pkg::MASK_W-1:0] mask_q;
	logic              last_q;

	// Effective frame size
	always_comb begin
		if (cfg_width_q == '0) begin
			w_m1 = '0;
		end else if (32'(cfg_width_q) > 32'(MAX_WIDTH)) begin
			w_m1 = CW'(MAX_WIDTH - 1);
		end else begin
			w_m1 = CW'(32'(cfg_width_q) - 32'd1);
		end
		h_m1  = (cfg_height_q == '0) ? '0 : cfg_height_q - HW'(1);
		delay = DW'(HALF * (32'(w_m1) + 32'd1) + HALF);
	end

	assign cfg_hit = cfg_wr_en && ((cfg_index == usm_pkg::REG_WIDTH) ||
		(cfg_index == usm_pkg::REG_HEIGHT) || (cfg_index == usm_pkg::REG_GAIN));

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= usm_pkg::WIDTH_RST;
			cfg_height_q <= usm_pkg::HEIGHT_RST;
			cfg_gain_q   <= usm_pkg::GAIN_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				usm_pkg::REG_WIDTH:  cfg_width_q  <= cfg_data[usm_pkg::WIDTH_W-1:0];
				usm_pkg::REG_HEIGHT: cfg_height_q <= cfg_data[HW-1:0];
				usm_pkg::REG_GAIN:   cfg_gain_q   <= cfg_data[usm_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Input handshake and beat classification
	assign adv1     = v1_q && en2;
	assign in_stall = v1_q && !en2;
	assign accept   = in_valid && !in_stall;
	assign drop     = (kind == usm_pkg::KIND_DRAIN) && !in_done_q;
	assign take     = accept && !drop;
	assign col_wrap = (in_col_q == w_m1);
	assign emit0    = started_q || (prime_q == delay);
	assign last0    = (orow_q == h_m1) && (ocol_q == w_m1);
	assign border0  = !((orow_q >= HW'(HALF)) &&
		({1'b0, orow_q} + (HW + 1)'(HALF) <= {1'b0, h_m1}) &&
		(ocol_q >= CW'(HALF)) &&
		({1'b0, ocol_q} + (CW + 1)'(HALF) <= {1'b0, w_m1}));

	// Advance input and output positions; restart on frame end or register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			in_done_q <= 1'b0;
			prime_q   <= '0;
			started_q <= 1'b0;
			ocol_q    <= '0;
			orow_q    <= '0;
		end else if (cfg_hit) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			in_done_q <= 1'b0;
			prime_q   <= '0;
			started_q <= 1'b0;
			ocol_q    <= '0;
			orow_q    <= '0;
		end else if (take) begin
			in_col_q <= col_wrap ? '0 : in_col_q + CW'(1);
			if (!in_done_q && col_wrap) begin
				if (in_row_q == h_m1) begin
					in_done_q <= 1'b1;
				end else begin
					in_row_q <= in_row_q + HW'(1);
				end
			end
			if (!started_q) begin
				if (prime_q == delay) begin
					started_q <= 1'b1;
				end else begin
					prime_q <= prime_q + DW'(1);
				end
			end
			if (emit0) begin
				if (ocol_q == w_m1) begin
					ocol_q <= '0;
					orow_q <= orow_q + HW'(1);
				end else begin
					ocol_q <= ocol_q + CW'(1);
				end
			end
			if (emit0 && last0) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				in_done_q <= 1'b0;
				prime_q   <= '0;
				started_q <= 1'b0;
				ocol_q    <= '0;
				orow_q    <= '0;
			end
		end
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (!v1_q || en2) begin
			v1_q <= take;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (take) begin
			val_s1    <= in_done_q ? '0 : pixel_in;
			col_s1    <= in_col_q;
			emit_s1   <= emit0;
			border_s1 <= border0;
			last_s1   <= last0;
		end
	end

	usm_lines #(
		.DEPTH  (MAX_WIDTH),
		.WORD_W (LROWS * PW)
	) u_lines (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (take),
		.rd_addr (in_col_q),
		.wr_en   (adv1),
		.wr_addr (col_s1),
		.wr_data (wr_word),
		.rd_data (rd_word)
	);

	// Build the incoming column and push each stored row down by one
	always_comb begin
		col_vec[0]        = val_s1;
		wr_word[PW-1:0]   = val_s1;
		for (int k = 1; k < WINDOW_SIZE; k++) begin
			col_vec[k] = rd_word[(k-1)*PW +: PW];
		end
		for (int k = 1; k < LROWS; k++) begin
			wr_word[k*PW +: PW] = rd_word[(k-1)*PW +: PW];
		end
	end

	// Window cell chain, newest column first
	for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
		if (i == 0) begin : g_head
			usm_cell #(
				.ROWS   (WINDOW_SIZE),
				.CSUM_W (CSUM_W)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift   (adv1),
				.col_in  (col_vec),
				.col_out (win[i]),
				.sum_out (csum[i])
			);
		end else begin : g_tail
			usm_cell #(
				.ROWS   (WINDOW_SIZE),
				.CSUM_W (CSUM_W)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift   (adv1),
				.col_in  (win[i-1]),
				.col_out (win[i]),
				.sum_out (csum[i])
			);
		end
	end

	// Window sum from the column sums
	always_comb begin
		win_sum = '0;
		for (int i = 0; i < WINDOW_SIZE; i++) begin
			win_sum = win_sum + SUM_W'(csum[i]);
		end
	end

	// Stage enables: a stage moves when empty or when the next one moves
	assign en_out = !vout_q || !out_stall;
	assign en6    = !v6_q || en_out;
	assign en5    = !v5_q || en6;
	assign en4    = !v4_q || en5;
	assign en3    = !v3_q || en4;
	assign en2    = !v2_q || en3;

	// Valid bits of the arithmetic stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q   <= 1'b0;
			v3_q   <= 1'b0;
			v4_q   <= 1'b0;
			v5_q   <= 1'b0;
			v6_q   <= 1'b0;
			vout_q <= 1'b0;
		end else begin
			if (en2) begin
				v2_q <= adv1 && emit_s1;
			end
			if (en3) begin
				v3_q <= v2_q;
			end
			if (en4) begin
				v4_q <= v3_q;
			end
			if (en5) begin
				v5_q <= v4_q;
			end
			if (en6) begin
				v6_q <= v5_q;
			end
			if (en_out) begin
				vout_q <= v6_q;
			end
		end
	end

	// Divide by the window area through a reciprocal
	assign blur_prod = PROD_W'(sum_s3) * PROD_W'(RECIP);
	assign blur_eff  = border_s4 ? pix_s4 : blur_s4;
	assign mask_abs  = mask_s5[usm_pkg::MASK_W-1] ? PW'(-mask_s5) : PW'(mask_s5);
	assign gain_prod = (PW + usm_pkg::GAIN_W)'(mask_abs) *
		(PW + usm_pkg::GAIN_W)'(cfg_gain_q);
	assign sharp_wide = neg_s6 ?
		$signed(SHARP_W'(pix_s6)) - $signed(SHARP_W'(mag_s6)) :
		$signed(SHARP_W'(pix_s6)) + $signed(SHARP_W'(mag_s6));

	// Arithmetic stage payloads
	always_ff @(posedge clk) begin
		if (en2 && adv1) begin
			border_s2 <= border_s1;
			last_s2   <= last_s1;
		end
		if (en3) begin
			sum_s3    <= win_sum;
			pix_s3    <= win[HALF][HALF];
			border_s3 <= border_s2;
			last_s3   <= last_s2;
		end
		if (en4) begin
			blur_s4   <= blur_prod[SH +: PW];
			pix_s4    <= pix_s3;
			border_s4 <= border_s3;
			last_s4   <= last_s3;
		end
		if (en5) begin
			mask_s5 <= $signed({1'b0, pix_s4}) - $signed({1'b0, blur_eff});
			pix_s5  <= pix_s4;
			blur_s5 <= blur_eff;
			last_s5 <= last_s4;
		end
		if (en6) begin
			mag_s6  <= gain_prod[usm_pkg::GAIN_FRAC +: MAG_W];
			neg_s6  <= mask_s5[usm_pkg::MASK_W-1];
			mask_s6 <= mask_s5;
			pix_s6  <= pix_s5;
			blur_s6 <= blur_s5;
			last_s6 <= last_s5;
		end
		if (en_out) begin
			if (sharp_wide < 0) begin
				sharp_q <= '0;
			end else if (sharp_wide > $signed(SHARP_W'(255))) begin
				sharp_q <= '1;
			end else begin
				sharp_q <= sharp_wide[PW-1:0];
			end
			blur_q <= blur_s6;
			mask_q <= mask_s6;
			last_q <= last_s6;
		end
	end

	assign out_valid   = vout_q;
	assign sharpened   = sharp_q;
	assign blurred     = blur_q;
	assign detail_mask = mask_q;
	assign frame_end   = last_q;

endmodule

[rtl/usm_lines.sv]
// Line store: one word per column holding every buffered row, with read bypass.
module usm_lines #(
	parameter int DEPTH  = 1024,
	parameter int WORD_W = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WORD_W-1:0]        wr_data,
	output logic [WORD_W-1:0]        rd_data
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] mem_rd_q;
	logic [WORD_W-1:0] byp_word_q;
	logic              byp_q;

	// Write the shifted column, read the next column
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q   <= mem[rd_addr];
			byp_word_q <= wr_data;
		end
	end

	// Flag a read that collides with the write of the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd_en) begin
			byp_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = byp_q ? byp_word_q : mem_rd_q;

endmodule

[rtl/usm_cell.sv]
// Window cell: holds one column of the window and its column sum.
module usm_cell #(
	parameter int ROWS   = 5,
	parameter int CSUM_W = 11
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                shift,
	input  logic [ROWS-1:0][usm_pkg::PIX_W-1:0] col_in,
	output logic [ROWS-1:0][usm_pkg::PIX_W-1:0] col_out,
	output logic [CSUM_W-1:0]                   sum_out
);

	logic [CSUM_W-1:0] sum_in;

	// Add up the incoming column
	always_comb begin
		sum_in = '0;
		for (int k = 0; k < ROWS; k++) begin
			sum_in = sum_in + CSUM_W'(col_in[k]);
		end
	end

	// Take the incoming column on each shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_out <= '0;
			sum_out <= '0;
		end else if (shift) begin
			col_out <= col_in;
			sum_out <= sum_in;
		end
	end

endmodule
